// ===== design/greedy_grid_point_clusterer_defines.svh =====
// Assertion macros used by the clusterer controller.
`ifndef GREEDY_GRID_POINT_CLUSTERER_DEFINES_SVH
`define GREEDY_GRID_POINT_CLUSTERER_DEFINES_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define GGPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ggpc check failed");
// Check a property on every clock edge, reset included.
`define GGPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("ggpc check failed");
`else
`define GGPC_ASSERT(lbl, prop)
`define GGPC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/ggpc_pkg.sv =====
// Shared constants, command/status types and helpers of the clusterer.
`timescale 1ns / 1ps
package ggpc_pkg;

  localparam int GRID_SIDE_MAX = 128;
  localparam int COORD_W       = $clog2(GRID_SIDE_MAX);
  localparam int ADDR_W        = 2 * COORD_W;
  localparam int COUNT_W       = 24;
  localparam int MAX_CLUSTERS  = 32;
  localparam int CI_W          = 5;
  localparam int FILL_W        = 6;
  localparam int DIST_W        = 2 * COORD_W + 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input commands
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH      = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_CLUSTER_SPACING = 2'd2;

  // Datapath commands from the controller
  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic add_rd;
    logic add_wr;
    logic run_init;
    logic scan_init;
    logic rd_pix;
    logic pix_adv;
    logic ci_clr;
    logic ci_inc;
    logic take_best;
    logic mark_lo;
    logic pick;
    logic ovf_wr;
    logic abs_acc;
    logic add_cl;
    logic near_step;
    logic lo_add;
    logic emit;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic in_grid;
    logic grid_empty;
    logic cand;
    logic fill_zero;
    logic close;
    logic ci_last;
    logic pix_last;
    logic win_last;
    logic best_zero;
    logic tab_full;
    logic lo_zero;
    logic clr_last;
    logic out_free;
  } sts_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

// ===== design/ggpc_datapath.sv =====
// Datapath: grid memories, cluster table, scan counters and result register.
`timescale 1ns / 1ps
module ggpc_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [7:0]                         cfg_wdata_i,
  input  logic signed [11:0]                 pixel_x_i,
  input  logic signed [11:0]                 pixel_y_i,
  input  logic [19:0]                        marker_count_i,
  input  ggpc_pkg::cmd_t                     cmd_i,
  output ggpc_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [6:0]                         cluster_x_o,
  output logic [6:0]                         cluster_y_o,
  output logic [23:0]                        cluster_total_o,
  output logic [4:0]                         cluster_number_o,
  output logic                               no_clusters_o,
  output logic                               overflow_o,
  output logic                               last_o
);

  localparam int CW = ggpc_pkg::COORD_W;
  localparam int AW = ggpc_pkg::ADDR_W;
  localparam int NW = ggpc_pkg::COUNT_W;
  localparam int KW = ggpc_pkg::CI_W;
  localparam int FW = ggpc_pkg::FILL_W;
  localparam int DW = ggpc_pkg::DIST_W;

  // Configuration registers
  logic [7:0] w_q, h_q, sp_q;
  logic [7:0] w_eff, h_eff, wm1, hm1;
  logic [6:0] half;
  logic [5:0] rad;
  logic [DW-2:0] limit;

  // Grid memories
  logic [NW-1:0] cnt_mem [2**AW];
  logic [NW-1:0] lft_mem [2**AW];
  logic [NW-1:0] cnt_rd_q, lft_rd_q, cnt_wdata, lft_wdata;
  logic [AW-1:0] cnt_raddr, cnt_waddr, lft_raddr, lft_waddr;
  logic          cnt_re, cnt_we, lft_re, lft_we;

  // Working registers
  logic [AW-1:0] clr_q, add_addr_q;
  logic [19:0]   add_cnt_q;
  logic [CW-1:0] px_q, py_q, bx_q, by_q, wx0_q, wx1_q, wy1_q;
  logic [NW-1:0] best_q, total_q;
  logic [KW-1:0] ci_q, near_q;
  logic [FW-1:0] fill_q;
  logic [DW-1:0] nd_q;
  logic          ovf_q;

  // Cluster table
  logic [CW-1:0] tab_x_q [ggpc_pkg::MAX_CLUSTERS];
  logic [CW-1:0] tab_y_q [ggpc_pkg::MAX_CLUSTERS];
  logic [NW-1:0] tab_tot_q [ggpc_pkg::MAX_CLUSTERS];

  logic [AW-1:0] pix_addr, b_addr, in_addr;
  logic [KW-1:0] tidx;
  logic [NW-1:0] tot_rd;
  logic [CW-1:0] tx, ty, adx, ady;
  logic [DW-1:0] pix_dist;
  logic [7:0]    xs, ys;
  logic [CW-1:0] wx0, wx1, wy0, wy1;
  logic          out_valid_q, out_free;

  // Derived configuration values
  assign w_eff = (w_q > 8'(ggpc_pkg::GRID_SIDE_MAX)) ? 8'(ggpc_pkg::GRID_SIDE_MAX) : w_q;
  assign h_eff = (h_q > 8'(ggpc_pkg::GRID_SIDE_MAX)) ? 8'(ggpc_pkg::GRID_SIDE_MAX) : h_q;
  assign wm1   = w_eff - 8'd1;
  assign hm1   = h_eff - 8'd1;
  assign half  = sp_q[7:1];
  assign rad   = sp_q[7:2];
  assign limit = half * half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= 8'd128;
      h_q  <= 8'd128;
      sp_q <= 8'd60;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ggpc_pkg::REG_GRID_WIDTH:      w_q  <= cfg_wdata_i;
        ggpc_pkg::REG_GRID_HEIGHT:     h_q  <= cfg_wdata_i;
        ggpc_pkg::REG_CLUSTER_SPACING: sp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pix_addr = {py_q, px_q};
  assign b_addr   = {by_q, bx_q};
  assign in_addr  = {pixel_y_i[CW-1:0], pixel_x_i[CW-1:0]};

  // Count grid port selection
  assign cnt_re    = cmd_i.add_rd | cmd_i.rd_pix;
  assign cnt_raddr = cmd_i.add_rd ? in_addr : pix_addr;
  assign cnt_we    = cmd_i.clr_step | cmd_i.add_wr | cmd_i.mark_lo | cmd_i.pick |
                     cmd_i.abs_acc;
  always_comb begin
    cnt_waddr = pix_addr;
    cnt_wdata = '0;
    if (cmd_i.clr_step) begin
      cnt_waddr = clr_q;
    end else if (cmd_i.add_wr) begin
      cnt_waddr = add_addr_q;
      cnt_wdata = ggpc_pkg::sat_add(cnt_rd_q, {4'b0, add_cnt_q});
    end else if (cmd_i.pick) begin
      cnt_waddr = b_addr;
    end
  end

  // Leftover grid port selection
  assign lft_re    = cmd_i.rd_pix | cmd_i.pick;
  assign lft_raddr = cmd_i.pick ? b_addr : pix_addr;
  assign lft_we    = cmd_i.clr_step | cmd_i.mark_lo | cmd_i.ovf_wr;
  always_comb begin
    lft_waddr = pix_addr;
    lft_wdata = '0;
    if (cmd_i.clr_step) begin
      lft_waddr = clr_q;
    end else if (cmd_i.mark_lo) begin
      lft_wdata = ggpc_pkg::sat_add(lft_rd_q, cnt_rd_q);
    end else if (cmd_i.ovf_wr) begin
      lft_waddr = b_addr;
      lft_wdata = ggpc_pkg::sat_add(lft_rd_q, best_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lft_we) lft_mem[lft_waddr] <= lft_wdata;
    if (lft_re) lft_rd_q <= lft_mem[lft_raddr];
  end

  // Squared distance from the current pixel to cluster ci
  assign tx       = tab_x_q[ci_q];
  assign ty       = tab_y_q[ci_q];
  assign adx      = (px_q >= tx) ? px_q - tx : tx - px_q;
  assign ady      = (py_q >= ty) ? py_q - ty : ty - py_q;
  assign pix_dist = DW'({{CW{1'b0}}, adx} * {{CW{1'b0}}, adx}) +
                    DW'({{CW{1'b0}}, ady} * {{CW{1'b0}}, ady});

  // Absorb window, clipped to the grid
  assign xs  = {1'b0, bx_q} + {2'b0, rad};
  assign ys  = {1'b0, by_q} + {2'b0, rad};
  assign wx0 = ({1'b0, bx_q} >= {2'b0, rad}) ? CW'({1'b0, bx_q} - {2'b0, rad}) : '0;
  assign wy0 = ({1'b0, by_q} >= {2'b0, rad}) ? CW'({1'b0, by_q} - {2'b0, rad}) : '0;
  assign wx1 = (xs > wm1) ? wm1[CW-1:0] : xs[CW-1:0];
  assign wy1 = (ys > hm1) ? hm1[CW-1:0] : ys[CW-1:0];

  // Hold latched point and clear sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_rd) begin
      add_addr_q <= in_addr;
      add_cnt_q  <= marker_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_init) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Advance pixel and window coordinates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
    end else if (cmd_i.scan_init) begin
      px_q <= '0;
      py_q <= '0;
    end else if (cmd_i.pick) begin
      px_q <= wx0;
      py_q <= wy0;
    end else if (cmd_i.abs_acc) begin
      if (px_q == wx1_q) begin
        px_q <= wx0_q;
        py_q <= py_q + CW'(1);
      end else begin
        px_q <= px_q + CW'(1);
      end
    end else if (cmd_i.pix_adv) begin
      if ({1'b0, px_q} == wm1) begin
        px_q <= '0;
        py_q <= py_q + CW'(1);
      end else begin
        px_q <= px_q + CW'(1);
      end
    end
  end

  // Track best candidate, window and running total
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      best_q <= '0;
    end else if (cmd_i.take_best) begin
      best_q <= cnt_rd_q;
      bx_q   <= px_q;
      by_q   <= py_q;
    end
    if (cmd_i.pick) begin
      total_q <= best_q;
      wx0_q   <= wx0;
      wx1_q   <= wx1;
      wy1_q   <= wy1;
    end else if (cmd_i.abs_acc) begin
      total_q <= ggpc_pkg::sat_add(total_q, cnt_rd_q);
    end
    if (cmd_i.near_step && (ci_q == '0 || pix_dist < nd_q)) begin
      nd_q   <= pix_dist;
      near_q <= ci_q;
    end
  end

  // Cluster index, fill and overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q   <= '0;
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (cmd_i.ci_clr) begin
        ci_q <= '0;
      end else if (cmd_i.ci_inc || cmd_i.emit) begin
        ci_q <= ci_q + KW'(1);
      end
      if (cmd_i.run_init) begin
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        if (cmd_i.add_cl) fill_q <= fill_q + FW'(1);
        if (cmd_i.ovf_wr) ovf_q <= 1'b1;
      end
    end
  end

  // Cluster table writes
  assign tidx   = cmd_i.emit ? ci_q : near_q;
  assign tot_rd = tab_tot_q[tidx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_cl) begin
      tab_x_q[fill_q[KW-1:0]]   <= bx_q;
      tab_y_q[fill_q[KW-1:0]]   <= by_q;
      tab_tot_q[fill_q[KW-1:0]] <= total_q;
    end else if (cmd_i.lo_add) begin
      tab_tot_q[near_q] <= ggpc_pkg::sat_add(tot_rd, lft_rd_q);
    end
  end

  // Result register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      overflow_o <= ovf_q;
      if (fill_q == '0) begin
        cluster_x_o      <= '0;
        cluster_y_o      <= '0;
        cluster_total_o  <= '0;
        cluster_number_o <= '0;
        no_clusters_o    <= 1'b1;
        last_o           <= 1'b1;
      end else begin
        cluster_x_o      <= tx;
        cluster_y_o      <= ty;
        cluster_total_o  <= tot_rd;
        cluster_number_o <= ci_q;
        no_clusters_o    <= 1'b0;
        last_o           <= sts_o.ci_last;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign sts_o.in_grid    = !pixel_x_i[11] && !pixel_y_i[11] &&
                            ({1'b0, pixel_x_i[10:0]} < {4'b0, w_eff}) &&
                            ({1'b0, pixel_y_i[10:0]} < {4'b0, h_eff});
  assign sts_o.grid_empty = (w_eff == '0) || (h_eff == '0);
  assign sts_o.cand       = cnt_rd_q > best_q;
  assign sts_o.fill_zero  = fill_q == '0;
  assign sts_o.close      = pix_dist < {1'b0, limit};
  assign sts_o.ci_last    = {1'b0, ci_q} == fill_q - FW'(1);
  assign sts_o.pix_last   = ({1'b0, px_q} == wm1) && ({1'b0, py_q} == hm1);
  assign sts_o.win_last   = (px_q == wx1_q) && (py_q == wy1_q);
  assign sts_o.best_zero  = best_q == '0;
  assign sts_o.tab_full   = fill_q == FW'(ggpc_pkg::MAX_CLUSTERS);
  assign sts_o.lo_zero    = lft_rd_q == '0;
  assign sts_o.clr_last   = &clr_q;
  assign sts_o.out_free   = out_free;

endmodule

// ===== design/ggpc_controller.sv =====
// Controller: sequences grid clears, loading, scan passes, absorption, leftovers and emission.
`timescale 1ns / 1ps
`include "greedy_grid_point_clusterer_defines.svh"
module ggpc_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           cmd_i,
  input  ggpc_pkg::sts_t sts_i,
  output ggpc_pkg::cmd_t cmd_o
);

  localparam logic [4:0] S_CLR_RST = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_ADD_WR  = 5'd2;
  localparam logic [4:0] S_SCAN_RD = 5'd3;
  localparam logic [4:0] S_SCAN_EV = 5'd4;
  localparam logic [4:0] S_SCAN_TC = 5'd5;
  localparam logic [4:0] S_PICK    = 5'd6;
  localparam logic [4:0] S_OVF_WR  = 5'd7;
  localparam logic [4:0] S_ABS_RD  = 5'd8;
  localparam logic [4:0] S_ABS_ACC = 5'd9;
  localparam logic [4:0] S_ADD_CL  = 5'd10;
  localparam logic [4:0] S_LO_RD   = 5'd11;
  localparam logic [4:0] S_LO_EV   = 5'd12;
  localparam logic [4:0] S_LO_NR   = 5'd13;
  localparam logic [4:0] S_LO_ADD  = 5'd14;
  localparam logic [4:0] S_CLR_RUN = 5'd15;
  localparam logic [4:0] S_EMIT    = 5'd16;

  logic [4:0] state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLR_RST: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      // Take one transfer: load a point, drop one outside the grid, or start a run
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == ggpc_pkg::CMD_RUN) begin
            cmd_o.run_init  = 1'b1;
            cmd_o.scan_init = 1'b1;
            state_d = sts_i.grid_empty ? S_PICK : S_SCAN_RD;
          end else if (sts_i.in_grid) begin
            cmd_o.add_rd = 1'b1;
            state_d      = S_ADD_WR;
          end
        end
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd_o.rd_pix = 1'b1;
        state_d      = S_SCAN_EV;
      end
      // Skip, accept, or test the pixel against existing clusters
      S_SCAN_EV: begin
        if (!sts_i.cand || sts_i.fill_zero) begin
          cmd_o.take_best = sts_i.cand;
          cmd_o.pix_adv   = 1'b1;
          state_d = sts_i.pix_last ? S_PICK : S_SCAN_RD;
        end else begin
          cmd_o.ci_clr = 1'b1;
          state_d      = S_SCAN_TC;
        end
      end
      S_SCAN_TC: begin
        if (sts_i.close || sts_i.ci_last) begin
          cmd_o.mark_lo   = sts_i.close;
          cmd_o.take_best = !sts_i.close;
          cmd_o.pix_adv   = 1'b1;
          state_d = sts_i.pix_last ? S_PICK : S_SCAN_RD;
        end else begin
          cmd_o.ci_inc = 1'b1;
        end
      end
      // Create a cluster, overflow the candidate, or finish the scan phase
      S_PICK: begin
        if (sts_i.best_zero) begin
          if (sts_i.fill_zero) begin
            cmd_o.clr_init = 1'b1;
            state_d        = S_CLR_RUN;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_LO_RD;
          end
        end else begin
          cmd_o.pick = 1'b1;
          state_d = sts_i.tab_full ? S_OVF_WR : S_ABS_RD;
        end
      end
      S_OVF_WR: begin
        cmd_o.ovf_wr    = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN_RD;
      end
      S_ABS_RD: begin
        cmd_o.rd_pix = 1'b1;
        state_d      = S_ABS_ACC;
      end
      S_ABS_ACC: begin
        cmd_o.abs_acc = 1'b1;
        state_d = sts_i.win_last ? S_ADD_CL : S_ABS_RD;
      end
      S_ADD_CL: begin
        cmd_o.add_cl    = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN_RD;
      end
      S_LO_RD: begin
        cmd_o.rd_pix = 1'b1;
        state_d      = S_LO_EV;
      end
      S_LO_EV: begin
        if (sts_i.lo_zero) begin
          cmd_o.pix_adv  = 1'b1;
          cmd_o.clr_init = sts_i.pix_last;
          state_d = sts_i.pix_last ? S_CLR_RUN : S_LO_RD;
        end else begin
          cmd_o.ci_clr = 1'b1;
          state_d      = S_LO_NR;
        end
      end
      // Find the nearest cluster, first index on ties
      S_LO_NR: begin
        cmd_o.near_step = 1'b1;
        if (sts_i.ci_last) begin
          state_d = S_LO_ADD;
        end else begin
          cmd_o.ci_inc = 1'b1;
        end
      end
      S_LO_ADD: begin
        cmd_o.lo_add   = 1'b1;
        cmd_o.pix_adv  = 1'b1;
        cmd_o.clr_init = sts_i.pix_last;
        state_d = sts_i.pix_last ? S_CLR_RUN : S_LO_RD;
      end
      S_CLR_RUN: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.ci_clr = 1'b1;
          state_d      = S_EMIT;
        end
      end
      // Hand out one result per free output slot
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.fill_zero || sts_i.ci_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_CLR_RST;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR_RST;
    end else begin
      state_q <= state_d;
    end
  end

  `GGPC_ASSERT(a_accept_only_idle, !in_stall_o |-> state_q == S_IDLE)
  `GGPC_ASSERT(a_no_reclear, state_q != S_CLR_RST |=> state_q != S_CLR_RST)
  `GGPC_ASSERT(a_add_after_idle, state_q == S_ADD_WR |-> $past(state_q) == S_IDLE)
  `GGPC_ASSERT(a_emit_needs_slot, cmd_o.emit |-> sts_i.out_free)

endmodule

// ===== design/greedy_grid_point_clusterer.sv =====
// Top level of the greedy grid point clusterer.
//
// Input channel (in_valid_i / in_stall_o): cmd_i = 0 adds pixel_x_i, pixel_y_i with
// weight marker_count_i into the count grid; points outside the grid are dropped.
// An add is a read-modify-write of the count memory, with in_stall_o high meanwhile.
// cmd_i = 1 runs clustering: repeated scans of the grid for the largest count,
// absorption of a window around each winner, a leftover pass that hands stray
// counts to the nearest cluster, then a clear of all 16384 cells of both grids.
// Output channel (out_valid_o / out_stall_i): one transfer per cluster in creation
// order, or one no_clusters result; last_o marks the final one. A stalled result
// holds in the output register and the emission waits for it.
// After reset the block clears both grids with in_stall_o high; configuration
// writes are taken at any time, registers reset to 128, 128, 60.
`timescale 1ns / 1ps
module greedy_grid_point_clusterer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [11:0] pixel_x_i,
  input  logic signed [11:0] pixel_y_i,
  input  logic [19:0]        marker_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         cluster_x_o,
  output logic [6:0]         cluster_y_o,
  output logic [23:0]        cluster_total_o,
  output logic [4:0]         cluster_number_o,
  output logic               no_clusters_o,
  output logic               overflow_o,
  output logic               last_o
);

  ggpc_pkg::cmd_t cmd;
  ggpc_pkg::sts_t sts;

  ggpc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ggpc_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pixel_x_i        (pixel_x_i),
    .pixel_y_i        (pixel_y_i),
    .marker_count_i   (marker_count_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cluster_x_o      (cluster_x_o),
    .cluster_y_o      (cluster_y_o),
    .cluster_total_o  (cluster_total_o),
    .cluster_number_o (cluster_number_o),
    .no_clusters_o    (no_clusters_o),
    .overflow_o       (overflow_o),
    .last_o           (last_o)
  );

endmodule
